>>> hw/rtl/sbe_pkg.sv
// Shared types and constants for the stack bytecode executor.
// Holds the item structs, opcode codes, status codes and register indexes.
`default_nettype none

package sbe_pkg;

  typedef struct packed {
    logic        command;
    logic [7:0]  opcode;
    logic [31:0] immediate;
    logic [15:0] pin_levels;
    logic [31:0] random_word;
    logic [31:0] elapsed_ticks;
  } sbe_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] next_pc;
    logic [1:0]  pin_action;
    logic [31:0] pin_id;
    logic        drive_level;
    logic [1:0]  delay_kind;
    logic [31:0] delay_amount;
    logic        seed_valid;
    logic [31:0] seed_value;
  } sbe_out_t;

  typedef struct packed {
    logic [7:0]  reg_index;
    logic [31:0] wdata;
  } sbe_cfg_t;

  localparam logic [7:0] REG_PROGRAM_LENGTH = 8'd0;
  localparam logic [7:0] REG_TIMEOUT_TICKS  = 8'd1;

  localparam logic [31:0] EMPTY_TOP = 32'hFFFF_FFFF;

  localparam logic [2:0] ST_RUNNING  = 3'd0;
  localparam logic [2:0] ST_SUCCESS  = 3'd1;
  localparam logic [2:0] ST_FAILURE  = 3'd2;
  localparam logic [2:0] ST_PC_OVF   = 3'd3;
  localparam logic [2:0] ST_OP_OVF   = 3'd4;
  localparam logic [2:0] ST_CALL_OVF = 3'd5;
  localparam logic [2:0] ST_TIMEOUT  = 3'd6;
  localparam logic [2:0] ST_INVALID  = 3'd7;

  localparam logic [1:0] PIN_NONE  = 2'd0;
  localparam logic [1:0] PIN_SET   = 2'd1;
  localparam logic [1:0] PIN_RESET = 2'd2;
  localparam logic [1:0] PIN_WRITE = 2'd3;

  localparam logic [1:0] DELAY_NONE = 2'd0;
  localparam logic [1:0] DELAY_MS   = 2'd1;
  localparam logic [1:0] DELAY_US   = 2'd2;

  localparam logic [7:0] OP_ADD     = 8'd0;
  localparam logic [7:0] OP_SUB     = 8'd1;
  localparam logic [7:0] OP_MUL     = 8'd2;
  localparam logic [7:0] OP_RNG     = 8'd3;
  localparam logic [7:0] OP_SEED    = 8'd4;
  localparam logic [7:0] OP_OR      = 8'd20;
  localparam logic [7:0] OP_XOR     = 8'd21;
  localparam logic [7:0] OP_AND     = 8'd22;
  localparam logic [7:0] OP_NOT     = 8'd23;
  localparam logic [7:0] OP_NEG     = 8'd24;
  localparam logic [7:0] OP_SHL     = 8'd25;
  localparam logic [7:0] OP_SHR     = 8'd26;
  localparam logic [7:0] OP_BOOL    = 8'd27;
  localparam logic [7:0] OP_LNOT    = 8'd28;
  localparam logic [7:0] OP_JMP     = 8'd40;
  localparam logic [7:0] OP_ALLOC   = 8'd41;
  localparam logic [7:0] OP_CALL    = 8'd42;
  localparam logic [7:0] OP_RET     = 8'd43;
  localparam logic [7:0] OP_EQ      = 8'd44;
  localparam logic [7:0] OP_NE      = 8'd45;
  localparam logic [7:0] OP_GT      = 8'd46;
  localparam logic [7:0] OP_LT      = 8'd47;
  localparam logic [7:0] OP_GE      = 8'd48;
  localparam logic [7:0] OP_LE      = 8'd49;
  localparam logic [7:0] OP_JNZ     = 8'd50;
  localparam logic [7:0] OP_JZ      = 8'd51;
  localparam logic [7:0] OP_PUSHI   = 8'd60;
  localparam logic [7:0] OP_PUSHC   = 8'd61;
  localparam logic [7:0] OP_LOADL   = 8'd62;
  localparam logic [7:0] OP_STOREL  = 8'd63;
  localparam logic [7:0] OP_POP     = 8'd64;
  localparam logic [7:0] OP_LOADG   = 8'd65;
  localparam logic [7:0] OP_STOREG  = 8'd66;
  localparam logic [7:0] OP_PINRD   = 8'd81;
  localparam logic [7:0] OP_PINWR   = 8'd82;
  localparam logic [7:0] OP_DELAYMS = 8'd100;
  localparam logic [7:0] OP_DELAYUS = 8'd101;
  localparam logic [7:0] OP_PSET_LO = 8'd111;
  localparam logic [7:0] OP_PSET_HI = 8'd126;
  localparam logic [7:0] OP_PCLR_LO = 8'd141;
  localparam logic [7:0] OP_PCLR_HI = 8'd156;
  localparam logic [7:0] OP_PGET_LO = 8'd171;
  localparam logic [7:0] OP_PGET_HI = 8'd186;
  localparam logic [7:0] OP_SUCCESS = 8'd201;
  localparam logic [7:0] OP_FAIL    = 8'd202;

endpackage

`default_nettype wire

>>> hw/rtl/sbe_stream_if.sv
// Valid/ready channel carrying one payload struct per item.
// The payload type comes from sbe_pkg at each instance.
`default_nettype none

interface sbe_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sbe_alu.sv
// Two-operand arithmetic, logic, shift and compare unit.
// Depends on sbe_pkg for the opcode codes.
`default_nettype none

module sbe_alu (
  input  wire logic [7:0]  opcode,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] result
);
  import sbe_pkg::*;

  logic shift_ok;

  assign shift_ok = (b[31:5] == 27'd0);

  always_comb begin
    case (opcode)
      OP_ADD:  result = a + b;
      OP_SUB:  result = a - b;
      OP_MUL:  result = a * b;
      OP_OR:   result = a | b;
      OP_XOR:  result = a ^ b;
      OP_AND:  result = a & b;
      OP_SHL:  result = shift_ok ? (a << b[4:0]) : 32'd0;
      OP_SHR:  result = shift_ok ? (a >> b[4:0]) : 32'd0;
      OP_EQ:   result = {31'd0, a == b};
      OP_NE:   result = {31'd0, a != b};
      OP_GT:   result = {31'd0, a > b};
      OP_LT:   result = {31'd0, a < b};
      OP_GE:   result = {31'd0, a >= b};
      default: result = {31'd0, a <= b};
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/stack_bytecode_executor_core.sv
// Stack bytecode executor: one instruction per item. The accept step takes
// the item and reads both stack memories; the execute step executes, writes
// back and loads the result register, waiting while that register holds a
// result not yet taken. The next item is accepted after that, so only one
// item is in flight at a time. Reset is synchronous and clears pc, base, both
// stack tops, flags and config registers; memory contents are not cleared.
`default_nettype none

module stack_bytecode_executor_core #(
  parameter int OPERAND_DEPTH   = 256,
  parameter int CALL_DEPTH      = 256,
  parameter int OVERFLOW_MARGIN = 10
) (
  input  wire logic   clk,
  input  wire logic   rst,
  sbe_stream_if.sink   instr,
  sbe_stream_if.source result,
  sbe_stream_if.sink   cfg
);
  import sbe_pkg::*;

  localparam int OAW = $clog2(OPERAND_DEPTH);
  localparam int CAW = $clog2(CALL_DEPTH);
  localparam logic [31:0] OP_DEPTH32 = 32'(OPERAND_DEPTH);
  localparam logic [31:0] CS_DEPTH32 = 32'(CALL_DEPTH);
  localparam logic [31:0] OP_LIMIT   = 32'(OPERAND_DEPTH - OVERFLOW_MARGIN);
  localparam logic [31:0] CS_LIMIT   = 32'(CALL_DEPTH - OVERFLOW_MARGIN);

  logic [16:0] program_length;
  logic [31:0] timeout_ticks;
  logic [31:0] pc, fb, otop, ctop;
  logic [31:0] pc_next, fb_next, otop_next, ctop_next;
  logic        busy, res_valid;
  sbe_in_t     item;
  sbe_out_t    res, res_next;

  logic [31:0] op_mem [OPERAND_DEPTH];
  logic [31:0] cs_mem [CALL_DEPTH];
  logic [31:0] op_rd_a, op_rd_b, cs_rd_c, cs_rd_d;
  logic        ok_a, ok_b, ok_c, ok_d;
  logic [31:0] ra_a, ra_b, ra_c, ra_d;

  logic        acc, exec_fire;
  logic        op_we, cs_we;
  logic [31:0] op_wa, op_wd, cs_wa, cs_wd;
  logic [31:0] va, vb, vc, vd, alu_t;

  assign acc       = instr.valid && !busy;
  assign exec_fire = busy && (!res_valid || result.ready);
  assign instr.ready  = !busy;
  assign cfg.ready    = 1'b1;
  assign result.valid = res_valid;
  assign result.data  = res;

  assign ra_a = otop - 32'd1;
  assign ra_b = otop;
  assign ra_d = fb - 32'd1;
  always_comb begin
    unique case (instr.data.opcode)
      OP_RET:   ra_c = fb;
      OP_LOADL: ra_c = fb + instr.data.immediate;
      default:  ra_c = instr.data.immediate;
    endcase
  end

  always_ff @(posedge clk) begin
    if (op_we && (op_wa < OP_DEPTH32)) begin
      op_mem[op_wa[OAW-1:0]] <= op_wd;
    end
    if (acc) begin
      op_rd_a <= op_mem[ra_a[OAW-1:0]];
      op_rd_b <= op_mem[ra_b[OAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cs_we && (cs_wa < CS_DEPTH32)) begin
      cs_mem[cs_wa[CAW-1:0]] <= cs_wd;
    end
    if (acc) begin
      cs_rd_c <= cs_mem[ra_c[CAW-1:0]];
      cs_rd_d <= cs_mem[ra_d[CAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      item <= instr.data;
      ok_a <= ra_a < OP_DEPTH32;
      ok_b <= ra_b < OP_DEPTH32;
      ok_c <= ra_c < CS_DEPTH32;
      ok_d <= ra_d < CS_DEPTH32;
    end
  end

  assign va = ok_a ? op_rd_a : 32'd0;
  assign vb = ok_b ? op_rd_b : 32'd0;
  assign vc = ok_c ? cs_rd_c : 32'd0;
  assign vd = ok_d ? cs_rd_d : 32'd0;

  sbe_alu u_alu (
    .opcode (item.opcode),
    .a      (va),
    .b      (vb),
    .result (alu_t)
  );

  function automatic logic [31:0] pin_read(input logic [15:0] levels,
                                           input logic [31:0] pin);
    logic [31:0] r;
    r = 32'd0;
    if (pin[31:4] == 28'd0) begin
      r = {31'd0, levels[pin[3:0]]};
    end
    return r;
  endfunction

  always_comb begin
    logic [31:0] next1, next5;
    logic [7:0]  pidx;
    next1 = pc + 32'd1;
    next5 = pc + 32'd5;
    pidx  = 8'd0;
    pc_next = pc;
    fb_next = fb;
    otop_next = otop;
    ctop_next = ctop;
    op_we = 1'b0;
    op_wa = otop;
    op_wd = 32'd0;
    cs_we = 1'b0;
    cs_wa = ctop + 32'd1;
    cs_wd = 32'd0;
    res_next = '0;
    res_next.status = ST_RUNNING;
    if (item.command) begin
      pc_next = 32'd0;
      fb_next = 32'd0;
      otop_next = EMPTY_TOP;
      ctop_next = EMPTY_TOP;
    end else if ({15'd0, pc} >= {30'd0, program_length}) begin
      res_next.status = ST_PC_OVF;
    end else if (otop != EMPTY_TOP && otop > OP_LIMIT) begin
      res_next.status = ST_OP_OVF;
    end else if (ctop != EMPTY_TOP && ctop > CS_LIMIT) begin
      res_next.status = ST_CALL_OVF;
    end else if (item.elapsed_ticks > timeout_ticks) begin
      res_next.status = ST_TIMEOUT;
    end else if (item.opcode inside {[OP_ADD:OP_MUL], [OP_OR:OP_AND], OP_SHL, OP_SHR,
                                     [OP_EQ:OP_LE]}) begin
      otop_next = otop - 32'd1;
      op_we = 1'b1;
      op_wa = otop - 32'd1;
      op_wd = alu_t;
      pc_next = next1;
    end else if (item.opcode >= OP_PSET_LO && item.opcode <= OP_PSET_HI) begin
      pidx = item.opcode - OP_PSET_LO;
      res_next.pin_action = PIN_SET;
      res_next.pin_id = {24'd0, pidx};
      pc_next = next1;
    end else if (item.opcode >= OP_PCLR_LO && item.opcode <= OP_PCLR_HI) begin
      pidx = item.opcode - OP_PCLR_LO;
      res_next.pin_action = PIN_RESET;
      res_next.pin_id = {24'd0, pidx};
      pc_next = next1;
    end else if (item.opcode >= OP_PGET_LO && item.opcode <= OP_PGET_HI) begin
      pidx = item.opcode - OP_PGET_LO;
      otop_next = otop + 32'd1;
      op_we = 1'b1;
      op_wa = otop + 32'd1;
      op_wd = pin_read(item.pin_levels, {24'd0, pidx});
      pc_next = next1;
    end else begin
      unique case (item.opcode)
        OP_RNG: begin
          otop_next = otop + 32'd1;
          op_we = 1'b1;
          op_wa = otop + 32'd1;
          op_wd = item.random_word;
          pc_next = next1;
        end
        OP_SEED: begin
          res_next.seed_valid = 1'b1;
          res_next.seed_value = vb;
          otop_next = otop - 32'd1;
          pc_next = next1;
        end
        OP_NOT, OP_NEG, OP_BOOL, OP_LNOT, OP_PINRD: begin
          op_we = 1'b1;
          case (item.opcode)
            OP_NOT:  op_wd = ~vb;
            OP_NEG:  op_wd = 32'd0 - vb;
            OP_BOOL: op_wd = {31'd0, vb != 32'd0};
            OP_LNOT: op_wd = {31'd0, vb == 32'd0};
            default: op_wd = pin_read(item.pin_levels, vb);
          endcase
          pc_next = next1;
        end
        OP_JMP: pc_next = item.immediate;
        OP_ALLOC: begin
          cs_we = 1'b1;
          cs_wd = fb;
          fb_next = ctop + 32'd1;
          ctop_next = ctop + 32'd1 + item.immediate;
          pc_next = next5;
        end
        OP_CALL: begin
          cs_we = 1'b1;
          cs_wd = next5;
          ctop_next = ctop + 32'd1;
          pc_next = item.immediate;
        end
        OP_RET: begin
          fb_next = vc;
          ctop_next = fb - 32'd2 - item.immediate;
          pc_next = vd;
        end
        OP_JNZ: begin
          pc_next = (vb != 32'd0) ? item.immediate : next5;
          otop_next = otop - 32'd1;
        end
        OP_JZ: begin
          pc_next = (vb == 32'd0) ? item.immediate : next5;
          otop_next = otop - 32'd1;
        end
        OP_PUSHI, OP_LOADL, OP_LOADG: begin
          otop_next = otop + 32'd1;
          op_we = 1'b1;
          op_wa = otop + 32'd1;
          op_wd = (item.opcode == OP_PUSHI) ? item.immediate : vc;
          pc_next = next5;
        end
        OP_PUSHC: begin
          cs_we = 1'b1;
          cs_wd = vb;
          ctop_next = ctop + 32'd1;
          otop_next = otop - 32'd1;
          pc_next = next1;
        end
        OP_STOREL, OP_STOREG: begin
          cs_we = 1'b1;
          cs_wa = (item.opcode == OP_STOREL) ? fb + item.immediate : item.immediate;
          cs_wd = vb;
          otop_next = otop - 32'd1;
          pc_next = next5;
        end
        OP_POP: begin
          otop_next = otop - 32'd1;
          pc_next = next1;
        end
        OP_PINWR: begin
          res_next.drive_level = vb != 32'd0;
          res_next.pin_id = va;
          res_next.pin_action = PIN_WRITE;
          otop_next = otop - 32'd2;
          pc_next = next1;
        end
        OP_DELAYMS, OP_DELAYUS: begin
          res_next.delay_kind = (item.opcode == OP_DELAYMS) ? DELAY_MS : DELAY_US;
          res_next.delay_amount = vb;
          otop_next = otop - 32'd1;
          pc_next = next1;
        end
        OP_SUCCESS: res_next.status = ST_SUCCESS;
        OP_FAIL:    res_next.status = ST_FAILURE;
        default:    res_next.status = ST_INVALID;
      endcase
    end
    res_next.next_pc = pc_next;
    if (!exec_fire) begin
      op_we = 1'b0;
      cs_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= 32'd0;
      fb <= 32'd0;
      otop <= EMPTY_TOP;
      ctop <= EMPTY_TOP;
      busy <= 1'b0;
      res_valid <= 1'b0;
      program_length <= 17'd0;
      timeout_ticks <= 32'hFFFF_FFFF;
    end else begin
      if (cfg.valid) begin
        if (cfg.data.reg_index == REG_PROGRAM_LENGTH) begin
          program_length <= cfg.data.wdata[16:0];
        end else if (cfg.data.reg_index == REG_TIMEOUT_TICKS) begin
          timeout_ticks <= cfg.data.wdata;
        end
      end
      if (acc) begin
        busy <= 1'b1;
      end else if (exec_fire) begin
        busy <= 1'b0;
      end
      if (exec_fire) begin
        pc <= pc_next;
        fb <= fb_next;
        otop <= otop_next;
        ctop <= ctop_next;
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      res <= res_next;
    end
  end

  a_exec_slot_free: assert property (@(posedge clk) disable iff (rst)
    exec_fire |-> !(res_valid && !result.ready))
    else $error("execute step overwrote a waiting result");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (rst)
    exec_fire |=> res_valid)
    else $error("execute step produced no result");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    !(acc && (op_we || cs_we)))
    else $error("stack write overlapped a stack read");

  a_fault_keeps_pc: assert property (@(posedge clk) disable iff (rst)
    (exec_fire && res_next.status != ST_RUNNING) |=> pc == $past(pc))
    else $error("faulting step changed the pc");

endmodule

`default_nettype wire
